@@ rtl/core/mips_subset_single_cycle_core_assert.svh @@
// ============================================================================
// mips_subset_single_cycle_core_assert.svh
// Assertion macros for the core RTL.
// ============================================================================
`ifndef MIPS_SUBSET_SINGLE_CYCLE_CORE_ASSERT_SVH
`define MIPS_SUBSET_SINGLE_CYCLE_CORE_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define MSC_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("msc: same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define MSC_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("msc: next-cycle check failed");

`endif

@@ rtl/core/msc_pkg.sv @@
// ============================================================================
// msc_pkg
// Opcodes, constants and shared types of the MIPS subset core.
// ============================================================================
package msc_pkg;

    localparam int DATA_BYTES_DEF = 4096;
    localparam int OQ_DEPTH       = 4;

    localparam logic [5:0] OPC_RTYPE = 6'b000000;
    localparam logic [5:0] OPC_J     = 6'b000010;
    localparam logic [5:0] OPC_BEQ   = 6'b000100;
    localparam logic [5:0] OPC_ADDIU = 6'b001001;
    localparam logic [5:0] OPC_LW    = 6'b100011;
    localparam logic [5:0] OPC_SW    = 6'b101011;

    localparam logic [2:0] FN_ADDU = 3'd1;
    localparam logic [2:0] FN_SUBU = 3'd3;
    localparam logic [2:0] FN_AND  = 3'd4;
    localparam logic [2:0] FN_OR   = 3'd5;
    localparam logic [2:0] FN_NOR  = 3'd7;

    localparam logic [31:0] HALT_WORD = 32'hFFFF_FFFF;

    // Execute stage outcome.
    typedef struct packed {
        logic [31:0] npc;
        logic        rf_we;
        logic [4:0]  rf_addr;
        logic [31:0] rf_data;
        logic        load;
        logic        store;
        logic        fault;
        logic [31:0] ea;
    } ex_t;

    // Data memory request from the execute stage.
    typedef struct packed {
        logic        store;
        logic        preload;
        logic [31:0] ea;
        logic [31:0] wdata;
        logic [11:0] paddr;
        logic [7:0]  pbyte;
    } dmem_req_t;

    // One result transaction.
    typedef struct packed {
        logic [31:0] next_pc;
        logic        halted;
        logic        reg_write;
        logic [4:0]  write_reg;
        logic [31:0] write_value;
        logic        mem_store;
        logic        mem_fault;
    } result_t;

endpackage

@@ rtl/core/msc_ram.sv @@
// ============================================================================
// msc_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ============================================================================
module msc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read returns old data on a same-address write.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/msc_exec.sv @@
// ============================================================================
// msc_exec
// Decode, ALU, branch/jump target and effective address with range check.
// ============================================================================
module msc_exec
    import msc_pkg::*;
#(
    parameter int DATA_BYTES = DATA_BYTES_DEF
) (
    input  logic [31:0] instr,
    input  logic [31:0] opa,
    input  logic [31:0] opb,
    input  logic [31:0] pc,
    output ex_t         ex
);

    logic [31:0] pc4;
    logic [31:0] imm;
    logic [31:0] ea;
    logic        in_rng;

    always_comb
    begin
        pc4    = pc + 32'd4;
        imm    = {{16{instr[15]}}, instr[15:0]};
        ea     = opa + imm;
        in_rng = ea < 32'(DATA_BYTES - 3);
        ex     = '0;
        ex.npc = pc4;
        ex.ea  = ea;
        unique case (instr[31:26]) inside
            OPC_RTYPE:
            begin
                ex.rf_addr = instr[15:11];
                ex.rf_we   = 1'b1;
                unique case (instr[2:0])
                    FN_ADDU: ex.rf_data = opa + opb;
                    FN_SUBU: ex.rf_data = opa - opb;
                    FN_AND:  ex.rf_data = opa & opb;
                    FN_OR:   ex.rf_data = opa | opb;
                    FN_NOR:  ex.rf_data = ~(opa | opb);
                    default:
                    begin
                        ex.rf_we   = 1'b0;
                        ex.rf_addr = 5'd0;
                    end
                endcase
            end
            OPC_ADDIU:
            begin
                ex.rf_we   = 1'b1;
                ex.rf_addr = instr[20:16];
                ex.rf_data = ea;
            end
            OPC_LW, OPC_SW:
            begin
                if (!in_rng)
                begin
                    ex.fault = 1'b1;
                end
                else if (instr[31:26] == OPC_LW)
                begin
                    ex.load    = 1'b1;
                    ex.rf_we   = 1'b1;
                    ex.rf_addr = instr[20:16];
                end
                else
                begin
                    ex.store = 1'b1;
                end
            end
            OPC_BEQ:
            begin
                if (opa == opb)
                begin
                    ex.npc = pc4 + {imm[29:0], 2'b00};
                end
            end
            OPC_J:
            begin
                ex.npc = {pc4[31:28], instr[25:0], 2'b00};
            end
            default:
            begin
                ex.npc = pc4;
            end
        endcase
    end

endmodule

@@ rtl/core/msc_dmem.sv @@
// ============================================================================
// msc_dmem
// Byte data memory as four byte-interleaved banks, unaligned big-endian
// word access, byte preload and a zero-fill pass after reset.
// ============================================================================
module msc_dmem
    import msc_pkg::*;
#(
    parameter int DATA_BYTES = DATA_BYTES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  dmem_req_t req,
    output logic      busy,
    output logic [31:0] rword
);

    localparam int BANK_DEPTH = (DATA_BYTES + 3) / 4;
    localparam int RW         = $clog2(BANK_DEPTH);

    logic          clr_busy_reg;
    logic [RW-1:0] clr_cnt_reg;
    logic [1:0]    lane_reg;
    logic [7:0]    bank_q [4];
    logic [31:0]   pa32;

    function automatic logic [7:0] word_byte(logic [31:0] w, logic [1:0] i);
        logic [7:0] b;
        case (i)
            2'd0:    b = w[31:24];
            2'd1:    b = w[23:16];
            2'd2:    b = w[15:8];
            default: b = w[7:0];
        endcase
        return b;
    endfunction

    assign pa32 = {20'd0, req.paddr};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == RW'(BANK_DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // Bank that holds the first (most significant) byte of the read word.
    always_ff @(posedge clk)
    begin
        lane_reg <= req.ea[1:0];
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_bank
        logic [1:0]    ofs;
        logic [31:0]   baddr;
        logic [RW-1:0] row;
        logic          we;
        logic [RW-1:0] wrow;
        logic [7:0]    wd;

        always_comb
        begin
            ofs   = 2'(k) - req.ea[1:0];
            baddr = req.ea + {30'd0, ofs};
            row   = baddr[RW+1:2];
            we    = 1'b0;
            wrow  = row;
            wd    = word_byte(req.wdata, ofs);
            if (clr_busy_reg)
            begin
                we   = 1'b1;
                wrow = clr_cnt_reg;
                wd   = 8'd0;
            end
            else if (req.store)
            begin
                we = 1'b1;
            end
            else if (req.preload && (req.paddr[1:0] == 2'(k)))
            begin
                we   = 1'b1;
                wrow = pa32[RW+1:2];
                wd   = req.pbyte;
            end
        end

        msc_ram #(
            .WIDTH (8),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .clk   (clk),
            .we    (we),
            .waddr (wrow),
            .wdata (wd),
            .raddr (row),
            .rdata (bank_q[k])
        );
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            rword[31-8*i -: 8] = bank_q[2'(lane_reg + 2'(i))];
        end
    end

    assign busy = clr_busy_reg;

endmodule

@@ rtl/core/msc_outq.sv @@
// ============================================================================
// msc_outq
// Result queue that decouples the pipeline from output stall.
// ============================================================================
module msc_outq
    import msc_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  result_t                       push_res,
    input  logic                          stall,
    output logic                          valid,
    output result_t                       res,
    output logic [$clog2(OQ_DEPTH+1)-1:0] count
);

    localparam int PW = $clog2(OQ_DEPTH);
    localparam int CW = $clog2(OQ_DEPTH + 1);

    result_t       entry_reg [OQ_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          pop;

    assign valid = count_reg != '0;
    assign pop   = valid && !stall;
    assign res   = entry_reg[rd_ptr_reg];
    assign count = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_res;
        end
    end

endmodule

@@ rtl/core/mips_subset_single_cycle_core.sv @@
// ============================================================================
// mips_subset_single_cycle_core
// MIPS subset core: one instruction or data-memory preload per transaction.
// ============================================================================
// Path: accepted transactions pass stage A and stage B into the result queue.
// Throughput: one transaction per cycle while in_stall is low; lw blocks
//   the next accept because its register write waits for the registered
//   data-memory read. Reset: PC, halt flag and register valid bits clear
//   at once; the data memory is zero-filled with in_stall held high.
`include "mips_subset_single_cycle_core_assert.svh"

module mips_subset_single_cycle_core
    import msc_pkg::*;
#(
    parameter int DATA_BYTES = DATA_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [31:0] instr,
    input  logic [11:0] preload_addr,
    input  logic [7:0]  preload_byte,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] next_pc,
    output logic        halted,
    output logic        reg_write,
    output logic [4:0]  write_reg,
    output logic [31:0] write_value,
    output logic        mem_store,
    output logic        mem_fault
);

    localparam int CW = $clog2(OQ_DEPTH + 1);

    // ------------------------------------------------------------------
    // Architectural control state
    // ------------------------------------------------------------------
    logic [31:0] pc_reg;
    logic [31:0] pc_next;
    logic        halt_reg;
    logic        halt_next;
    logic [31:0] rf_valid_reg;   // entry never written reads as zero

    // Stage A: item captured, register file data arriving
    logic        a_vld_reg;
    logic        a_op_reg;
    logic [31:0] a_instr_reg;
    logic [11:0] a_paddr_reg;
    logic [7:0]  a_pbyte_reg;

    // Operand bypass captured at register-file read time
    logic        rs_fwd_reg;
    logic        rt_fwd_reg;
    logic [31:0] rs_fdat_reg;
    logic [31:0] rt_fdat_reg;
    logic        rs_vld_reg;
    logic        rt_vld_reg;

    // Stage B: result waiting on load data
    logic        b_vld_reg;
    logic        b_load_reg;
    result_t     b_res_reg;

    logic        accept;
    logic        clr_busy;
    logic        a_is_lw;
    logic        run;
    logic [31:0] rs_q;
    logic [31:0] rt_q;
    logic [31:0] opa;
    logic [31:0] opb;
    ex_t         ex;
    dmem_req_t   dreq;
    logic [31:0] dword;
    result_t     a_res;
    result_t     b_res;
    result_t     oq_res;
    logic [CW-1:0] oq_count;
    logic [CW-1:0] in_flight;

    // Register file write port: one writer per cycle (A for ALU ops,
    // B for loads; a load in A blocks the next accept, so never both).
    logic        a_rf_we;
    logic        b_rf_we;
    logic        rf_we;
    logic [4:0]  rf_wa;
    logic [31:0] rf_wd;

    // ------------------------------------------------------------------
    // Input handshake. Stall comes from state only: clearing pass, a load
    // in A (its data is not back yet), or no room left in the queue.
    // ------------------------------------------------------------------
    assign a_is_lw   = a_vld_reg && !a_op_reg && (a_instr_reg[31:26] == OPC_LW);
    assign in_flight = CW'(a_vld_reg) + CW'(b_vld_reg) + oq_count;
    assign in_stall  = clr_busy || a_is_lw || (in_flight >= CW'(OQ_DEPTH));
    assign accept    = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Register file: two copies, one per read port, written together.
    // Read address comes straight from the input word.
    // ------------------------------------------------------------------
    msc_ram #(
        .WIDTH (32),
        .DEPTH (32)
    ) u_rf_rs (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_wa),
        .wdata (rf_wd),
        .raddr (instr[25:21]),
        .rdata (rs_q)
    );

    msc_ram #(
        .WIDTH (32),
        .DEPTH (32)
    ) u_rf_rt (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_wa),
        .wdata (rf_wd),
        .raddr (instr[20:16]),
        .rdata (rt_q)
    );

    // RAM returns old data on a colliding write, so the write is bypassed.
    assign opa = rs_fwd_reg ? rs_fdat_reg : (rs_vld_reg ? rs_q : 32'd0);
    assign opb = rt_fwd_reg ? rt_fdat_reg : (rt_vld_reg ? rt_q : 32'd0);

    // ------------------------------------------------------------------
    // Stage A: execute
    // ------------------------------------------------------------------
    msc_exec #(
        .DATA_BYTES (DATA_BYTES)
    ) u_exec (
        .instr (a_instr_reg),
        .opa   (opa),
        .opb   (opb),
        .pc    (pc_reg),
        .ex    (ex)
    );

    // Halt word and already-halted cases do no work.
    assign run = a_vld_reg && !a_op_reg && !halt_reg && (a_instr_reg != HALT_WORD);

    always_comb
    begin
        pc_next   = run ? ex.npc : pc_reg;
        halt_next = halt_reg || (a_vld_reg && !a_op_reg && (a_instr_reg == HALT_WORD));

        a_res             = '0;
        a_res.next_pc     = pc_next;
        a_res.halted      = halt_next;
        a_res.reg_write   = run && ex.rf_we;
        a_res.write_reg   = (run && ex.rf_we) ? ex.rf_addr : 5'd0;
        a_res.write_value = (run && ex.rf_we && !ex.load) ? ex.rf_data : 32'd0;
        a_res.mem_store   = run && ex.store;
        a_res.mem_fault   = run && ex.fault;

        dreq         = '0;
        dreq.store   = run && ex.store;
        dreq.preload = a_vld_reg && a_op_reg && ({20'd0, a_paddr_reg} < 32'(DATA_BYTES));
        dreq.ea      = ex.ea;
        dreq.wdata   = opb;
        dreq.paddr   = a_paddr_reg;
        dreq.pbyte   = a_pbyte_reg;
    end

    msc_dmem #(
        .DATA_BYTES (DATA_BYTES)
    ) u_dmem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .busy  (clr_busy),
        .rword (dword)
    );

    // ------------------------------------------------------------------
    // Stage B: load data arrives and is merged into the result
    // ------------------------------------------------------------------
    always_comb
    begin
        b_res = b_res_reg;
        if (b_load_reg)
        begin
            b_res.write_value = dword;
        end
    end

    assign a_rf_we = run && ex.rf_we && !ex.load;
    assign b_rf_we = b_vld_reg && b_load_reg;
    assign rf_we   = a_rf_we || b_rf_we;
    assign rf_wa   = b_rf_we ? b_res_reg.write_reg : ex.rf_addr;
    assign rf_wd   = b_rf_we ? dword : ex.rf_data;

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    msc_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (b_vld_reg),
        .push_res (b_res),
        .stall    (out_stall),
        .valid    (out_valid),
        .res      (oq_res),
        .count    (oq_count)
    );

    assign next_pc     = oq_res.next_pc;
    assign halted      = oq_res.halted;
    assign reg_write   = oq_res.reg_write;
    assign write_reg   = oq_res.write_reg;
    assign write_value = oq_res.write_value;
    assign mem_store   = oq_res.mem_store;
    assign mem_fault   = oq_res.mem_fault;

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg       <= '0;
            halt_reg     <= 1'b0;
            rf_valid_reg <= '0;
            a_vld_reg    <= 1'b0;
            b_vld_reg    <= 1'b0;
            b_load_reg   <= 1'b0;
        end
        else
        begin
            pc_reg     <= pc_next;
            halt_reg   <= halt_next;
            a_vld_reg  <= accept;
            b_vld_reg  <= a_vld_reg;
            b_load_reg <= run && ex.load;
            if (rf_we)
            begin
                rf_valid_reg[rf_wa] <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        a_op_reg    <= op;
        a_instr_reg <= instr;
        a_paddr_reg <= preload_addr;
        a_pbyte_reg <= preload_byte;
        rs_fwd_reg  <= rf_we && (rf_wa == instr[25:21]);
        rt_fwd_reg  <= rf_we && (rf_wa == instr[20:16]);
        rs_fdat_reg <= rf_wd;
        rt_fdat_reg <= rf_wd;
        rs_vld_reg  <= rf_valid_reg[instr[25:21]];
        rt_vld_reg  <= rf_valid_reg[instr[20:16]];
        b_res_reg   <= a_res;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `MSC_ASSERT_IMP(a_rf_rf_wr_excl, clk, rst_n, a_rf_we, !b_rf_we)
    `MSC_ASSERT_NXT(a_lw_bubble, clk, rst_n, a_is_lw, !a_vld_reg)
    `MSC_ASSERT_IMP(a_clr_idle, clk, rst_n, clr_busy, !a_vld_reg && !b_vld_reg)
    `MSC_ASSERT_NXT(a_halt_pc_hold, clk, rst_n, halt_reg, halt_reg && (pc_reg == $past(pc_reg)))

endmodule

@@ tb/sv/mips_subset_single_cycle_core_test.sv @@
// ============================================================================
// mips_subset_single_cycle_core_test
// Self-checking bench for the MIPS subset core. A queue of transactions
// (directed corner cases, then random programs built mostly from well-formed
// load/store, ALU and branch sequences) feeds a bursty driver. An
// in-bench instruction-set model predicts every result. A monitor behind a
// stalling receiver compares each result field by field.
// ============================================================================
module mips_subset_single_cycle_core_test
    import msc_pkg::*;
();

    // Transaction kinds on the op port.
    localparam logic OP_EXEC    = 1'b0;
    localparam logic OP_PRELOAD = 1'b1;

    localparam int RANDOM_ITEMS   = 1300;
    localparam int HOLD_AFTER     = 500;   // accepted inputs before the long hold-off
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;  // covers the memory clear pass and the hold-off
    localparam int DRAIN_CYCLES   = 20;

    typedef struct packed {
        logic        op;
        logic [31:0] instr;
        logic [11:0] paddr;
        logic [7:0]  pbyte;
    } stim_t;

    // Receiver stall patterns.
    typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        op = OP_EXEC;
    logic [31:0] instr = '0;
    logic [11:0] preload_addr = '0;
    logic [7:0]  preload_byte = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] next_pc;
    logic        halted;
    logic        reg_write;
    logic [4:0]  write_reg;
    logic [31:0] write_value;
    logic        mem_store;
    logic        mem_fault;

    mips_subset_single_cycle_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .instr        (instr),
        .preload_addr (preload_addr),
        .preload_byte (preload_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .next_pc      (next_pc),
        .halted       (halted),
        .reg_write    (reg_write),
        .write_reg    (write_reg),
        .write_value  (write_value),
        .mem_store    (mem_store),
        .mem_fault    (mem_fault)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Architectural state of the predictor
    // ------------------------------------------------------------------------
    logic [31:0] model_pc;
    logic [31:0] gpr [32];
    logic [7:0]  dmem [DATA_BYTES_DEF];
    logic        halt_seen;

    stim_t   stim_q[$];     // transactions waiting for the driver
    result_t retire_q[$];   // predicted retirement records, oldest first

    int fail_count   = 0;
    int results_seen = 0;
    int items_taken  = 0;
    int idle_cycles  = 0;
    bit in_taken     = 1'b0;
    bit out_taken    = 1'b0;

    // Executes one transaction against the predictor state and returns
    // what the core should report for it.
    function automatic result_t retire_item(input stim_t s);
        result_t     r;
        logic [5:0]  opc;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [31:0] imm;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] pc4;
        logic [31:0] npc;
        logic [31:0] ea;
        logic        alu_ok;
        r = '0;
        if (s.op == OP_PRELOAD) begin
            // 12-bit address always lands inside the 4 KiB memory
            dmem[s.paddr] = s.pbyte;
        end else if (!halt_seen) begin
            if (s.instr == HALT_WORD) begin
                halt_seen = 1'b1;   // PC stays put
            end else begin
                opc = s.instr[31:26];
                rs  = s.instr[25:21];
                rt  = s.instr[20:16];
                imm = {{16{s.instr[15]}}, s.instr[15:0]};
                a   = gpr[rs];
                b   = gpr[rt];
                pc4 = model_pc + 32'd4;
                npc = pc4;
                ea  = a + imm;
                case (opc)
                    OPC_RTYPE: begin
                        alu_ok = 1'b1;
                        case (s.instr[2:0])
                            FN_ADDU: r.write_value = a + b;
                            FN_SUBU: r.write_value = a - b;
                            FN_AND:  r.write_value = a & b;
                            FN_OR:   r.write_value = a | b;
                            FN_NOR:  r.write_value = ~(a | b);
                            default: alu_ok = 1'b0;
                        endcase
                        if (alu_ok) begin
                            r.reg_write = 1'b1;
                            r.write_reg = s.instr[15:11];
                        end else begin
                            r.write_value = '0;
                        end
                    end
                    OPC_ADDIU: begin
                        r.reg_write   = 1'b1;
                        r.write_reg   = rt;
                        r.write_value = ea;
                    end
                    OPC_LW, OPC_SW: begin
                        // no wrap: the last byte of the word must fit
                        if ({1'b0, ea} + 33'd3 >= 33'(DATA_BYTES_DEF)) begin
                            r.mem_fault = 1'b1;
                        end else if (opc == OPC_LW) begin
                            r.reg_write   = 1'b1;
                            r.write_reg   = rt;
                            r.write_value = {dmem[ea], dmem[ea + 1], dmem[ea + 2],
                                             dmem[ea + 3]};
                        end else begin
                            r.mem_store = 1'b1;
                            {dmem[ea], dmem[ea + 1], dmem[ea + 2], dmem[ea + 3]} = b;
                        end
                    end
                    OPC_BEQ: if (a == b) npc = pc4 + {imm[29:0], 2'b00};
                    OPC_J:   npc = {pc4[31:28], s.instr[25:0], 2'b00};
                    default: ;  // unknown opcode: PC advance only
                endcase
                if (r.reg_write) gpr[r.write_reg] = r.write_value;
                model_pc = npc;
            end
        end
        r.next_pc = model_pc;
        r.halted  = halt_seen;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at result %0d: %s got %h want %h",
                 results_seen, what, got, want);
        fail_count++;
    endtask

    task automatic check_result(input result_t w);
        if (next_pc !== w.next_pc)         report_mismatch("next_pc", next_pc, w.next_pc);
        if (halted !== w.halted)           report_mismatch("halted", 32'(halted), 32'(w.halted));
        if (reg_write !== w.reg_write)
            report_mismatch("reg_write", 32'(reg_write), 32'(w.reg_write));
        if (write_reg !== w.write_reg)
            report_mismatch("write_reg", 32'(write_reg), 32'(w.write_reg));
        if (write_value !== w.write_value)
            report_mismatch("write_value", write_value, w.write_value);
        if (mem_store !== w.mem_store)
            report_mismatch("mem_store", 32'(mem_store), 32'(w.mem_store));
        if (mem_fault !== w.mem_fault)
            report_mismatch("mem_fault", 32'(mem_fault), 32'(w.mem_fault));
    endtask

    // ------------------------------------------------------------------------
    // Instruction builders
    // ------------------------------------------------------------------------
    // Shamt and funct[5:3] are don't-care for the core, so they get noise.
    function automatic logic [31:0] r_word(input logic [4:0] rs, input logic [4:0] rt,
                                           input logic [4:0] rd, input logic [2:0] fn);
        return {OPC_RTYPE, rs, rt, rd, 5'($urandom), 3'($urandom), fn};
    endfunction

    function automatic logic [31:0] i_word(input logic [5:0] opc, input logic [4:0] rs,
                                           input logic [4:0] rt, input logic [15:0] imm);
        return {opc, rs, rt, imm};
    endfunction

    function automatic bit known_opcode(input logic [5:0] opc);
        return opc == OPC_RTYPE || opc == OPC_J || opc == OPC_BEQ || opc == OPC_ADDIU ||
               opc == OPC_LW || opc == OPC_SW;
    endfunction

    // Appends one transaction at the tail of the driver queue.
    task automatic enqueue(input stim_t s);
        stim_q.insert(stim_q.size(), s);
    endtask

    // Halt only goes in on purpose, at the tail: it sticks until reset.
    task automatic push_exec(input logic [31:0] w);
        stim_t s;
        s.op    = OP_EXEC;
        s.instr = (w == HALT_WORD) ? (HALT_WORD ^ 32'd1) : w;
        s.paddr = 12'($urandom);
        s.pbyte = 8'($urandom);
        enqueue(s);
    endtask

    task automatic push_preload(input logic [11:0] addr, input logic [7:0] value);
        enqueue({OP_PRELOAD, 32'($urandom), addr, value});
    endtask

    task automatic build_directed();
        // memory extremes; 4092 and 4095 are read back later through lw at 4092
        push_preload(12'd0, 8'hFF);
        push_preload(12'd4095, 8'hA5);
        push_preload(12'd4092, 8'h80);
        // immediate extremes: +32767 and sign-extended -32768
        push_exec(i_word(OPC_ADDIU, 5'd0, 5'd1, 16'h7FFF));
        push_exec(i_word(OPC_ADDIU, 5'd0, 5'd2, 16'h8000));
        // every ALU operation on those two values
        push_exec(r_word(5'd1, 5'd2, 5'd3, FN_ADDU));
        push_exec(r_word(5'd1, 5'd2, 5'd4, FN_SUBU));
        push_exec(r_word(5'd1, 5'd2, 5'd5, FN_AND));
        push_exec(r_word(5'd1, 5'd2, 5'd6, FN_OR));
        push_exec(r_word(5'd1, 5'd2, 5'd7, FN_NOR));
        // unknown funct and unknown opcode (one bit short of the halt word)
        push_exec({OPC_RTYPE, 5'd1, 5'd2, 5'd8, 5'h1F, 6'b111110});
        push_exec({6'h3F, 26'h3FF_FFFE});
        // R0 is writable; -1 + -1 wraps
        push_exec(i_word(OPC_ADDIU, 5'd0, 5'd0, 16'hFFFF));
        push_exec(r_word(5'd0, 5'd0, 5'd9, FN_ADDU));
        // top word of memory: load, store, reload, then faults
        push_exec(r_word(5'd10, 5'd10, 5'd10, FN_SUBU));
        push_exec(i_word(OPC_ADDIU, 5'd10, 5'd10, 16'd4092));
        push_exec(i_word(OPC_LW, 5'd10, 5'd11, 16'd0));
        push_exec(i_word(OPC_SW, 5'd10, 5'd1, 16'd0));
        push_exec(i_word(OPC_LW, 5'd10, 5'd12, 16'd0));
        push_exec(i_word(OPC_LW, 5'd10, 5'd13, 16'd1));      // last byte at 4096
        push_exec(i_word(OPC_SW, 5'd0, 5'd1, 16'hFFFF));     // address wraps to -2
        push_exec(i_word(OPC_LW, 5'd1, 5'd14, 16'h8000));    // 0xFFFFFFFF
        // branch both ways with extreme offsets, jump to both ends
        push_exec(i_word(OPC_BEQ, 5'd1, 5'd1, 16'h8000));
        push_exec(i_word(OPC_BEQ, 5'd1, 5'd2, 16'h7FFF));
        push_exec({OPC_J, 26'h3FF_FFFF});
        push_exec({OPC_J, 26'h000_0000});
    endtask

    // Random programs: mostly well-formed sequences with random content.
    task automatic build_random(input int total);
        int          pick;
        int          n;
        logic [4:0]  base;
        logic [4:0]  rs;
        logic [31:0] addr;
        logic [15:0] off;
        logic [5:0]  opc;
        while (stim_q.size() < total) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                // zero a base register, point it somewhere, then access near it
                base = 5'($urandom);
                pick = $urandom_range(0, 99);
                if (pick < 70)      addr = $urandom_range(0, 4095);
                else if (pick < 85) addr = $urandom_range(4088, 4100);
                else                addr = $urandom_range(0, 7);
                push_exec(r_word(base, base, base, FN_SUBU));
                push_exec(i_word(OPC_ADDIU, base, base, addr[15:0]));
                if ($urandom_range(0, 3) == 0)
                    for (int k = 0; k < 4; k++) push_preload(12'(addr + k), 8'($urandom));
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 60)      off = 16'($urandom_range(0, 16) - 8);
                    else if (pick < 85) off = 16'($urandom_range(0, 3));
                    else                off = 16'($urandom);
                    push_exec(i_word($urandom_range(0, 1) ? OPC_LW : OPC_SW, base,
                                     5'($urandom), off));
                end
            end else if (pick < 50) begin
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++) push_preload(12'($urandom), 8'($urandom));
            end else if (pick < 70) begin
                // funct[2:0] random: hits the unknown codes too
                push_exec(r_word(5'($urandom), 5'($urandom), 5'($urandom), 3'($urandom)));
            end else if (pick < 82) begin
                push_exec(i_word(OPC_ADDIU, 5'($urandom), 5'($urandom), 16'($urandom)));
            end else if (pick < 90) begin
                rs = 5'($urandom);
                push_exec(i_word(OPC_BEQ, rs, $urandom_range(0, 1) ? rs : 5'($urandom),
                                 16'($urandom)));
            end else if (pick < 94) begin
                push_exec({OPC_J, 26'($urandom)});
            end else if (pick < 97) begin
                do opc = 6'($urandom); while (known_opcode(opc));
                push_exec({opc, 26'($urandom)});
            end else begin
                push_exec($urandom);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: bursts of transactions with random gaps, changes at negedge
    // ------------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    task automatic offer(input stim_t s);
        op           <= s.op;
        instr        <= s.instr;
        preload_addr <= s.paddr;
        preload_byte <= s.pbyte;
    endtask

    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_taken) begin
            // stalled: payload holds
        end else if (in_valid && burst_left > 0 && stim_q.size() > 0) begin
            offer(stim_q.pop_front());
            burst_left <= burst_left - 1;
        end else if (in_valid) begin
            in_valid <= 1'b0;
            gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(4, 9)
                                                    : $urandom_range(0, 2);
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
        end else if (stim_q.size() > 0) begin
            offer(stim_q.pop_front());
            in_valid   <= 1'b1;
            // occasional long bursts give gap-free stretches
            burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(0, 12);
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: rotating stall patterns plus one long hold-off so the core
    // backs up and stalls its input while the driver keeps offering.
    // ------------------------------------------------------------------------
    rx_mode_t rx_mode   = RX_FREE;
    int       mode_left = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;

    always @(negedge clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if (!hold_done && items_taken >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (mode_left == 0) begin
            rx_mode   <= rx_mode_t'($urandom_range(0, 3));
            mode_left <= $urandom_range(20, 200);
            out_stall <= 1'b0;
        end else begin
            mode_left <= mode_left - 1;
            case (rx_mode)
                RX_FREE:  out_stall <= 1'b0;
                RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                default:  out_stall <= ~out_stall;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: both handshakes sampled at posedge. Results are checked
    // before the new input is predicted; a result can never belong to the
    // transaction accepted on the same edge.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        out_taken = rst_n && out_valid && !out_stall;
        in_taken  = rst_n && in_valid && !in_stall;
        if (out_taken) begin
            results_seen++;
            if (retire_q.size() == 0) report_mismatch("unexpected result", next_pc, '0);
            else                      check_result(retire_q.pop_front());
        end
        if (in_taken) begin
            retire_q.insert(retire_q.size(),
                            retire_item({op, instr, preload_addr, preload_byte}));
            items_taken++;
        end
        idle_cycles <= (in_taken || out_taken) ? 0 : idle_cycles + 1;
    end

    // Watchdog: no progress on either channel for too long.
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
        $display("watchdog: %0d cycles without a transaction", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus build, reset, drain and verdict
    // ------------------------------------------------------------------------
    initial begin
        model_pc  = '0;
        halt_seen = 1'b0;
        foreach (gpr[i])  gpr[i]  = '0;
        foreach (dmem[i]) dmem[i] = '0;

        build_directed();
        build_random(stim_q.size() + RANDOM_ITEMS);
        // Tail: halt sticks, so it comes last. Execute transactions after it
        // are ignored, a second halt changes nothing, preloads still land.
        enqueue({OP_EXEC, HALT_WORD, 12'($urandom), 8'($urandom)});
        push_exec($urandom);
        push_exec(i_word(OPC_ADDIU, 5'd1, 5'd1, 16'd1));
        enqueue({OP_EXEC, HALT_WORD, 12'($urandom), 8'($urandom)});
        push_preload(12'($urandom), 8'($urandom));
        push_exec({OPC_J, 26'($urandom)});

        // Reset is held, then released; the core then clears its memory with in_stall high
        repeat (3) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (stim_q.size() != 0 || in_valid || retire_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
